/* rtl/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros used by the checker file
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define BSB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define BSB_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bsb_pkg.sv */
// ------------------------------------------------------------------------
// bsb_pkg
// Shared constants and controller/datapath interface types for the
// bounded-staleness barrier.
// ------------------------------------------------------------------------
package bsb_pkg;

    // default sizing
    localparam int DEF_MAX_WORKERS = 16;
    localparam int DEF_COUNT_WIDTH = 32;

    // fixed field widths
    localparam int RANK_W     = 4;
    localparam int DELAY_W    = 8;
    localparam int ACTIVE_W   = 5;
    localparam int TDATA_W    = 8;
    localparam int CFG_DATA_W = 8;

    // active_workers value after reset
    localparam int ACTIVE_RESET = 16;

    // configuration register indexes
    localparam logic CFG_DELAY_LIMIT    = 1'b0;
    localparam logic CFG_ACTIVE_WORKERS = 1'b1;

    // request kinds
    localparam logic MODE_FINISH = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch the accepted request
        logic calc;         // bump count, classify, push, update minimum
        logic emit_imm;     // send the immediate release
        logic pop_rd;       // read top of held stack and pop it
        logic pop_emit;     // send the popped release
        logic scan_start;   // reset recount index
        logic scan_step;    // step the recount
    } bsb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic go;           // latched request is a finish from a live rank
        logic hold;         // request was held
        logic advance;      // minimum advanced
        logic pop_avail;    // another held entry may be released
        logic out_free;     // output register can take a result
        logic scan_done;    // recount finished
    } bsb_sts_t;

endpackage

/* rtl/bsb_ram.sv */
// ------------------------------------------------------------------------
// bsb_ram
// Generic single-write, single-read RAM with registered read data.
// ------------------------------------------------------------------------
module bsb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bsb_ctrl.sv */
// ------------------------------------------------------------------------
// bsb_ctrl
// Sequencer for the barrier: accept, classify, release, pop held
// requests, recount workers at the new minimum.
// ------------------------------------------------------------------------
module bsb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output bsb_pkg::bsb_cmd_t cmd,
    input  bsb_pkg::bsb_sts_t sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_IMM   = 3'd3;
    localparam logic [2:0] S_POPRD = 3'd4;
    localparam logic [2:0] S_POPEM = 3'd5;
    localparam logic [2:0] S_SCAN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = sts.go ? S_CALC : S_IDLE;
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_IMM;
            end
            S_IMM:
            begin
                if (sts.hold)
                begin
                    state_next = sts.advance ? S_POPRD : S_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_imm = 1'b1;
                    state_next   = sts.advance ? S_POPRD : S_IDLE;
                end
            end
            S_POPRD:
            begin
                if (sts.pop_avail)
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POPEM;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_POPEM:
            begin
                if (sts.out_free)
                begin
                    cmd.pop_emit = 1'b1;
                    state_next   = S_POPRD;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/bsb_dp.sv */
// ------------------------------------------------------------------------
// bsb_dp
// Barrier datapath: config registers, per-worker iteration counts,
// held stack, minimum tracking, recount and the output register.
// ------------------------------------------------------------------------
module bsb_dp #(
    parameter int MAX_WORKERS = bsb_pkg::DEF_MAX_WORKERS,
    parameter int COUNT_WIDTH = bsb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [bsb_pkg::TDATA_W-1:0]     s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [bsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  bsb_pkg::bsb_cmd_t               cmd,
    output bsb_pkg::bsb_sts_t               sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsb_pkg::TDATA_W-1:0]     m_tdata,
    output logic                            m_tlast
);

    localparam int WW     = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW     = $clog2(MAX_WORKERS + 1);
    localparam int INIT_N = (MAX_WORKERS < bsb_pkg::ACTIVE_RESET) ?
                            MAX_WORKERS : bsb_pkg::ACTIVE_RESET;
    localparam int PAD_W  = bsb_pkg::TDATA_W - bsb_pkg::RANK_W - 1;

    // config
    logic [bsb_pkg::DELAY_W-1:0]  delay_limit_reg;
    logic [bsb_pkg::ACTIVE_W-1:0] active_reg;
    logic [CW-1:0]                n_total;

    // request
    logic [bsb_pkg::RANK_W-1:0] rank_reg;
    logic                       mode_reg;
    logic [WW-1:0]              rank_addr;

    // barrier state
    logic [COUNT_WIDTH-1:0] slowest_reg;
    logic [COUNT_WIDTH-1:0] slowest_next;
    logic [CW-1:0]          pending_reg;
    logic [CW-1:0]          pending_next;
    logic [CW-1:0]          depth_reg;
    logic [CW-1:0]          depth_next;
    logic [CW-1:0]          depth_m1;
    logic [CW-1:0]          nres_reg;
    logic [CW-1:0]          nres_next;
    logic [CW-1:0]          nres_inc;
    logic [CW-1:0]          idx_reg;
    logic [CW-1:0]          idx_next;
    logic                   hold_reg;
    logic                   adv_reg;
    logic                   scan_v_reg;
    logic [MAX_WORKERS-1:0] cnt_valid_reg;
    logic                   cnt_vld_reg;

    // count memory
    logic [WW-1:0]          cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_rdata;
    logic [COUNT_WIDTH-1:0] cnt_cur;

    // held stack memory
    logic                        stk_we;
    logic [CW-1:0]               stk_raddr;
    logic [bsb_pkg::RANK_W-1:0]  stk_rdata;

    // calc and scan terms
    logic [COUNT_WIDTH-1:0] it_val;
    logic [COUNT_WIDTH-1:0] lead_d;
    logic                   ahead;
    logic                   hold;
    logic                   push;
    logic [CW-1:0]          pend_dec;
    logic                   adv;
    logic [COUNT_WIDTH-1:0] scan_lead;
    logic                   scan_ahead;
    logic                   scan_issue;

    // output register
    logic                       out_valid_reg;
    logic [bsb_pkg::RANK_W-1:0] out_rank_reg;
    logic                       out_held_reg;
    logic                       out_last_reg;
    logic                       out_free;
    logic                       imm_last;
    logic                       pop_last;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_limit_reg <= '0;
            active_reg      <= bsb_pkg::ACTIVE_W'(bsb_pkg::ACTIVE_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bsb_pkg::CFG_DELAY_LIMIT:
                begin
                    delay_limit_reg <= cfg_data;
                end
                bsb_pkg::CFG_ACTIVE_WORKERS:
                begin
                    active_reg <= cfg_data[bsb_pkg::ACTIVE_W-1:0];
                end
                default:
                begin
                    delay_limit_reg <= delay_limit_reg;
                end
            endcase
        end
    end

    // effective worker count, clamped to 1..MAX_WORKERS
    always_comb
    begin
        if (active_reg == '0)
        begin
            n_total = CW'(1);
        end
        else if (32'(active_reg) > 32'(MAX_WORKERS))
        begin
            n_total = CW'(MAX_WORKERS);
        end
        else
        begin
            n_total = CW'(active_reg);
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rank_reg <= s_tdata[bsb_pkg::RANK_W-1:0];
            mode_reg <= s_tuser[0];
        end
    end

    assign rank_addr = WW'(rank_reg);
    assign sts.go    = (mode_reg == bsb_pkg::MODE_FINISH) &&
                       (32'(rank_reg) < 32'(n_total));

    // count memory: rank during classify, scan index during recount
    assign scan_issue = cmd.scan_step && (idx_reg < n_total);
    assign cnt_raddr  = cmd.scan_step ? idx_reg[WW-1:0] : rank_addr;
    assign cnt_cur    = cnt_vld_reg ? cnt_rdata : '0;

    bsb_ram #(
        .WIDTH  (COUNT_WIDTH),
        .DEPTH  (MAX_WORKERS),
        .ADDR_W (WW)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.calc),
        .waddr (rank_addr),
        .wdata (it_val),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // held stack, grows upward from entry 0; after a pop the read address
    // stays on the popped entry until it is sent
    assign depth_m1  = depth_reg - CW'(1);
    assign stk_we    = cmd.calc && push;
    assign stk_raddr = cmd.pop_rd ? depth_m1 : depth_reg;

    bsb_ram #(
        .WIDTH  (bsb_pkg::RANK_W),
        .DEPTH  (MAX_WORKERS),
        .ADDR_W (WW)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[WW-1:0]),
        .wdata (rank_reg),
        .raddr (stk_raddr[WW-1:0]),
        .rdata (stk_rdata)
    );

    // classify the finishing worker
    assign it_val   = cnt_cur + COUNT_WIDTH'(1);
    assign lead_d   = it_val - slowest_reg;
    assign ahead    = (lead_d != '0) && !lead_d[COUNT_WIDTH-1];
    assign hold     = ahead && (lead_d > COUNT_WIDTH'(delay_limit_reg));
    assign push     = hold && (depth_reg < CW'(MAX_WORKERS));
    assign pend_dec = ((lead_d == COUNT_WIDTH'(1)) && (pending_reg != '0)) ?
                      (pending_reg - CW'(1)) : pending_reg;
    assign adv      = (pend_dec == '0);

    // recount term
    assign scan_lead  = cnt_cur - slowest_reg;
    assign scan_ahead = (scan_lead != '0) && !scan_lead[COUNT_WIDTH-1];

    // next values of barrier state
    always_comb
    begin
        slowest_next = slowest_reg;
        pending_next = pending_reg;
        depth_next   = depth_reg;
        nres_next    = nres_reg;
        idx_next     = idx_reg;
        if (cmd.calc)
        begin
            if (adv)
            begin
                pending_next = n_total;
                slowest_next = slowest_reg + COUNT_WIDTH'(1);
            end
            else
            begin
                pending_next = pend_dec;
            end
            if (push)
            begin
                depth_next = depth_reg + CW'(1);
            end
        end
        if (scan_v_reg && scan_ahead && (pending_reg != '0))
        begin
            pending_next = pending_reg - CW'(1);
        end
        if (cmd.pop_rd)
        begin
            depth_next = depth_m1;
        end
        if (cmd.capture)
        begin
            nres_next = '0;
        end
        else if (cmd.emit_imm || cmd.pop_emit)
        begin
            nres_next = nres_inc;
        end
        if (cmd.scan_start)
        begin
            idx_next = '0;
        end
        else if (scan_issue)
        begin
            idx_next = idx_reg + CW'(1);
        end
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slowest_reg   <= '0;
            pending_reg   <= CW'(INIT_N);
            depth_reg     <= '0;
            nres_reg      <= '0;
            idx_reg       <= '0;
            scan_v_reg    <= 1'b0;
            cnt_valid_reg <= '0;
            cnt_vld_reg   <= 1'b0;
            hold_reg      <= 1'b0;
            adv_reg       <= 1'b0;
        end
        else
        begin
            slowest_reg <= slowest_next;
            pending_reg <= pending_next;
            depth_reg   <= depth_next;
            nres_reg    <= nres_next;
            idx_reg     <= idx_next;
            scan_v_reg  <= scan_issue;
            cnt_vld_reg <= cnt_valid_reg[cnt_raddr];
            if (cmd.calc)
            begin
                cnt_valid_reg[rank_addr] <= 1'b1;
                hold_reg                 <= hold;
                adv_reg                  <= adv;
            end
        end
    end

    // last-result flags
    assign nres_inc = nres_reg + CW'(1);
    assign imm_last = !(adv_reg && (depth_reg != '0) &&
                        (nres_inc < CW'(MAX_WORKERS)));
    assign pop_last = (depth_reg == '0) || (nres_inc >= CW'(MAX_WORKERS));

    // output register
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_imm || cmd.pop_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_imm)
        begin
            out_rank_reg <= rank_reg;
            out_held_reg <= 1'b0;
            out_last_reg <= imm_last;
        end
        else if (cmd.pop_emit)
        begin
            out_rank_reg <= stk_rdata;
            out_held_reg <= 1'b1;
            out_last_reg <= pop_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_held_reg, out_rank_reg};
    assign m_tlast  = out_last_reg;

    // status
    assign sts.hold      = hold_reg;
    assign sts.advance   = adv_reg;
    assign sts.pop_avail = (depth_reg != '0) && (nres_reg < CW'(MAX_WORKERS));
    assign sts.out_free  = out_free;
    assign sts.scan_done = !scan_v_reg && (idx_reg == n_total);

endmodule

/* rtl/bounded_staleness_barrier_top.sv */
// ------------------------------------------------------------------------
// bounded_staleness_barrier_top
// Bounded-delay barrier for distributed workers: counts finished
// iterations per worker, holds workers too far ahead of the slowest and
// releases them when the minimum advances.
//
//   channel  dir  signals                        payload
//   s_*      in   s_tvalid s_tready              tdata[3:0] worker_rank
//                 s_tdata s_tuser                tuser[0]   mode
//   m_*      out  m_tvalid m_tready              tdata[3:0] released_rank
//                 m_tdata m_tlast                tdata[4] was_held, tlast
//   cfg_*    in   cfg_valid cfg_ready            index 0 delay limit,
//                 cfg_index cfg_data             index 1 active_workers
//
// One request at a time. An ignored request returns to idle after the
// check; a finish goes through check, calc and the immediate-release step,
// where a release is loaded unless the request is held. When the minimum
// advances, each held release takes a stack RAM read, then an output load,
// and the recount of the n active workers takes a start step, n count RAM
// reads and a pipeline drain. Output stalls extend the release steps.
// Reset is immediate: counts read as zero through per-worker valid bits.
// ------------------------------------------------------------------------
module bounded_staleness_barrier_top #(
    parameter int MAX_WORKERS = bsb_pkg::DEF_MAX_WORKERS,
    parameter int COUNT_WIDTH = bsb_pkg::DEF_COUNT_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bsb_pkg::TDATA_W-1:0]    s_tdata,   // [3:0] worker_rank
    input  logic [0:0]                     s_tuser,   // [0] mode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bsb_pkg::TDATA_W-1:0]    m_tdata,   // [3:0] released_rank, [4] was_held
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [bsb_pkg::CFG_DATA_W-1:0] cfg_data
);

    bsb_pkg::bsb_cmd_t cmd;
    bsb_pkg::bsb_sts_t sts;

    // sequencer
    bsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // datapath
    bsb_dp #(
        .MAX_WORKERS (MAX_WORKERS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/bsb_checker.sv */
// ------------------------------------------------------------------------
// bsb_checker
// Port-level checks for the barrier, bound to the top level.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module bsb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bsb_pkg::TDATA_W-1:0]    m_tdata,
    input logic                           m_tlast
);

    // one request in flight: intake closes right after an accept
    `BSB_ASSERT(a_one_in_flight, (s_tvalid && s_tready) |=> !s_tready, "request accepted while busy")

    // a stalled result stays put
    `BSB_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)), "stalled result changed")

    // padding bits of the result stay zero
    `BSB_ASSERT(a_out_pad, m_tvalid |-> (m_tdata[7:5] == 3'b000), "result padding not zero")

    // no result during reset
    `BSB_ASSERT_RST(a_rst_quiet, !rst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind bounded_staleness_barrier_top bsb_checker u_bsb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
